[hdl/rxs_pkg.sv]
// Shared types and microcode program for the record exchange sorter.
// Holds the control word layout, jump conditions and the program table.
// No dependencies.
package rxs_pkg;

    localparam int StepBits = 4;
    localparam int WordBits = 64;

    typedef logic [StepBits-1:0] step_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IDLE_HOLD,
        COND_J_MORE,
        COND_I_MORE
    } cond_t;

    typedef struct packed {
        logic  busy;
        logic  load;
        logic  ld_i;
        logic  clr_j;
        logic  cmp;
        logic  wb_i;
        logic  adv_i;
        logic  emit;
        logic  clr_cnt;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic start_last;
        logic j_last;
        logic i_last;
    } flags_t;

    localparam step_t StepIdle    = step_t'(0);
    localparam step_t StepRdI     = step_t'(1);
    localparam step_t StepLdI     = step_t'(2);
    localparam step_t StepRdJ     = step_t'(3);
    localparam step_t StepCmp     = step_t'(4);
    localparam step_t StepWbI     = step_t'(5);
    localparam step_t StepRdK     = step_t'(6);
    localparam step_t StepEmit    = step_t'(7);
    localparam step_t StepClose   = step_t'(8);

    localparam ctrl_t CtrlNop = '{busy: 1'b1, load: 1'b0, ld_i: 1'b0, clr_j: 1'b0,
                                  cmp: 1'b0, wb_i: 1'b0, adv_i: 1'b0, emit: 1'b0,
                                  clr_cnt: 1'b0, cond: COND_NEVER, target: StepIdle};

    // Program table: one control word per step, fall through to step + 1
    // unless the jump condition holds.
    function automatic ctrl_t rxs_ucode(input step_t step);
        ctrl_t w;
        w = CtrlNop;
        unique case (step)
            StepIdle:
            begin
                w.busy   = 1'b0;
                w.load   = 1'b1;
                w.cond   = COND_IDLE_HOLD;
                w.target = StepIdle;
            end
            StepRdI:
            begin
                w.cond = COND_NEVER;
            end
            StepLdI:
            begin
                w.ld_i  = 1'b1;
                w.clr_j = 1'b1;
            end
            StepRdJ:
            begin
                w.cond = COND_NEVER;
            end
            StepCmp:
            begin
                w.cmp    = 1'b1;
                w.cond   = COND_J_MORE;
                w.target = StepRdJ;
            end
            StepWbI:
            begin
                w.wb_i   = 1'b1;
                w.adv_i  = 1'b1;
                w.cond   = COND_I_MORE;
                w.target = StepRdI;
            end
            StepRdK:
            begin
                w.cond = COND_NEVER;
            end
            StepEmit:
            begin
                w.emit   = 1'b1;
                w.adv_i  = 1'b1;
                w.cond   = COND_I_MORE;
                w.target = StepRdK;
            end
            StepClose:
            begin
                w.clr_cnt = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = StepIdle;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = StepIdle;
            end
        endcase
        return w;
    endfunction

endpackage

[hdl/rxs_ram.sv]
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module rxs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hdl/rxs_seq.sv]
// Microcode sequencer: step counter, program table lookup, conditional jumps.
// Depends on rxs_pkg.
module rxs_seq
    import rxs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t upc_reg;
    step_t upc_next;
    logic  taken;

    assign ctrl = rxs_ucode(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_IDLE_HOLD: taken = !flags.start_last;
            COND_J_MORE:    taken = !flags.j_last;
            COND_I_MORE:    taken = !flags.i_last;
            default:        taken = 1'b1;
        endcase
        upc_next = taken ? ctrl.target : upc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= StepIdle;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // the final word of a set starts the sort at step RdI
    assert property (@(posedge clk) disable iff (!rst_n)
        flags.start_last |=> (upc_reg == StepRdI))
        else $error("sort did not start after the last word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && flags.i_last) |=> (upc_reg == StepClose))
        else $error("set not closed after final result");

endmodule

[hdl/rxs_dp.sv]
// Datapath: record count, sort indexes, held record, compare and write mux.
// Depends on rxs_pkg and rxs_ram.
module rxs_dp
    import rxs_pkg::*;
#(
    parameter int MAX_RECORDS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_t              ctrl,
    input  logic               start,
    input  logic signed [31:0] record_id,
    input  logic signed [31:0] score,
    input  logic               last_record,
    output flags_t             flags,
    output logic signed [31:0] out_id,
    output logic signed [31:0] out_score
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       i_reg, i_next;
    logic [AW-1:0]       j_reg, j_next;
    logic [WordBits-1:0] rec_i_reg, rec_i_next;

    logic                accept;
    logic                room;
    logic                swap;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [WordBits-1:0] wdata;
    logic [WordBits-1:0] rdata_a;
    logic [WordBits-1:0] rdata_b;
    logic [CW-1:0]       last_idx;

    assign accept   = start && !ctrl.busy;
    assign room     = count_reg < CW'(MAX_RECORDS);
    assign last_idx = count_reg - CW'(1);

    assign flags.start_last = accept && last_record;
    assign flags.i_last     = CW'(i_reg) == last_idx;
    assign flags.j_last     = CW'(j_reg) == last_idx;

    // position i holds its live value in rec_i; skip self so a stale read cannot swap
    assign swap = ctrl.cmp && (j_reg != i_reg) &&
                  ($signed(rec_i_reg[31:0]) > $signed(rdata_b[31:0]));

    always_comb
    begin
        we    = 1'b0;
        waddr = j_reg;
        wdata = rec_i_reg;
        priority if (ctrl.load && accept && room)
        begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = {record_id, score};
        end
        else if (swap)
        begin
            we    = 1'b1;
            waddr = j_reg;
            wdata = rec_i_reg;
        end
        else if (ctrl.wb_i)
        begin
            we    = 1'b1;
            waddr = i_reg;
            wdata = rec_i_reg;
        end
        else
        begin
            we    = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr_cnt)
        begin
            count_next = '0;
        end
        else if (ctrl.load && accept && room)
        begin
            count_next = count_reg + CW'(1);
        end

        i_next = i_reg;
        if (ctrl.adv_i)
        begin
            i_next = flags.i_last ? '0 : i_reg + AW'(1);
        end

        j_next = j_reg;
        if (ctrl.clr_j)
        begin
            j_next = '0;
        end
        else if (ctrl.cmp)
        begin
            j_next = j_reg + AW'(1);
        end

        rec_i_next = rec_i_reg;
        if (ctrl.ld_i)
        begin
            rec_i_next = rdata_a;
        end
        else if (swap)
        begin
            rec_i_next = rdata_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_i_reg <= rec_i_next;
    end

    rxs_ram #(
        .WIDTH (WordBits),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (i_reg),
        .raddr_b (j_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign out_id    = rdata_a[63:32];
    assign out_score = rdata_a[31:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit || ctrl.cmp) |-> (count_reg != '0))
        else $error("sort or emit with an empty store");

endmodule

[hdl/record_exchange_sort_desc_top.sv]
// Top level of the record exchange sorter, descending by score.
// Depends on rxs_pkg, rxs_seq, rxs_dp (and rxs_ram below it).
//
// Records (record_id, score) load one word per cycle while busy is low;
// words beyond MAX_RECORDS are dropped. The word with last_record set
// raises busy and starts an exchange sort of the n stored records run by a
// microcode program over one dual-read store: each outer pass loads record i,
// reads and compares every record j, and writes record i back. Results then
// leave on out_strobe, out_last on the final one, and the receiver cannot
// stall them.
module record_exchange_sort_desc_top
    import rxs_pkg::*;
#(
    parameter int MAX_RECORDS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] record_id,
    input  logic signed [31:0] score,
    input  logic               last_record,
    output logic               out_strobe,
    output logic signed [31:0] out_id,
    output logic signed [31:0] out_score,
    output logic               out_last
);

    ctrl_t  ctrl;
    flags_t flags;

    rxs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    rxs_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .start       (start),
        .record_id   (record_id),
        .score       (score),
        .last_record (last_record),
        .flags       (flags),
        .out_id      (out_id),
        .out_score   (out_score)
    );

    assign busy       = ctrl.busy;
    assign out_strobe = ctrl.emit;
    assign out_last   = ctrl.emit && flags.i_last;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> busy)
        else $error("result while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && out_last) |=> ##1 !busy)
        else $error("not ready after final result");

endmodule
